/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define DLM_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("dense layer assertion failed");

// Concurrent assertion that is also checked during reset.
`define DLM_ASSERT_RST(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("dense layer reset assertion failed");

`endif

/* hdl/dlm_pkg.sv */
// ----------------------------------------------------------------------------
// Dense layer package
// Types, constants and codes shared by the dense layer matrix-vector block.
// ----------------------------------------------------------------------------
package dlm_pkg;

  localparam int DEF_MAX_INPUTS  = 256;
  localparam int DEF_MAX_NEURONS = 64;
  localparam int DEF_DATA_WIDTH  = 16;

  localparam int FRAC_BITS  = 8;
  localparam int OPCODE_W   = 2;
  localparam int ADDR_W     = 14;
  localparam int NIDX_W     = 6;
  localparam int SUM_W      = 32;
  localparam int IC_W       = 9;
  localparam int NC_W       = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WEIGHT = 2'd0,
    OP_BIAS   = 2'd1,
    OP_INPUT  = 2'd2
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_COUNT  = 1'b0,
    CFG_NEURON_COUNT = 1'b1
  } cfg_index_e;

  typedef enum logic [1:0] {
    CMD_WEIGHT,
    CMD_BIAS,
    CMD_INPUT
  } cmd_kind_e;

  // A classified command as it travels from the front end to the back end.
  typedef struct packed {
    cmd_kind_e         kind;
    logic              store;
    logic              go;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MAC,
    B_DRAIN
  } back_state_e;

endpackage

/* hdl/dlm_if.sv */
// ----------------------------------------------------------------------------
// Dense layer channels
// Valid/ready channels for the input items and the neuron results.
// ----------------------------------------------------------------------------
interface dlm_in_if #(
  parameter int DATA_WIDTH = dlm_pkg::DEF_DATA_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic [dlm_pkg::OPCODE_W-1:0]  opcode;
  logic [dlm_pkg::ADDR_W-1:0]    address;
  logic signed [DATA_WIDTH-1:0]  value;
  logic                          last;

  modport source (output valid, opcode, address, value, last, input ready);
  modport sink   (input valid, opcode, address, value, last, output ready);
endinterface

interface dlm_out_if;
  logic                             valid;
  logic                             ready;
  logic [dlm_pkg::NIDX_W-1:0]       neuron_index;
  logic signed [dlm_pkg::SUM_W-1:0] sum;
  logic                             saturated;
  logic                             last_output;

  modport source (output valid, neuron_index, sum, saturated, last_output, input ready);
  modport sink   (input valid, neuron_index, sum, saturated, last_output, output ready);
endinterface

/* hdl/dlm_front.sv */
// ----------------------------------------------------------------------------
// Dense layer front end
// Accepts input items, decodes the opcode and range-checks the address.
// ----------------------------------------------------------------------------
module dlm_front #(
  parameter int DATA_WIDTH  = dlm_pkg::DEF_DATA_WIDTH,
  parameter int MAX_INPUTS  = dlm_pkg::DEF_MAX_INPUTS,
  parameter int MAX_NEURONS = dlm_pkg::DEF_MAX_NEURONS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  dlm_in_if.sink                in_ch,
  output logic                  push_valid_o,
  input  logic                  push_ready_i,
  output dlm_pkg::cmd_t         push_cmd_o,
  output logic [DATA_WIDTH-1:0] push_value_o
);

  localparam int WDEPTH = MAX_INPUTS * MAX_NEURONS;

  logic                  vld_q;
  dlm_pkg::cmd_t         cmd_q, cmd_d;
  logic [DATA_WIDTH-1:0] val_q;
  logic                  keep;

  assign in_ch.ready = !vld_q || push_ready_i;

  always_comb begin
    cmd_d      = '0;
    cmd_d.addr = in_ch.address;
    keep       = 1'b1;
    unique case (dlm_pkg::opcode_e'(in_ch.opcode))
      dlm_pkg::OP_WEIGHT: begin
        cmd_d.kind  = dlm_pkg::CMD_WEIGHT;
        cmd_d.store = 32'(in_ch.address) < 32'(WDEPTH);
      end
      dlm_pkg::OP_BIAS: begin
        cmd_d.kind  = dlm_pkg::CMD_BIAS;
        cmd_d.store = 32'(in_ch.address) < 32'(MAX_NEURONS);
      end
      dlm_pkg::OP_INPUT: begin
        cmd_d.kind  = dlm_pkg::CMD_INPUT;
        cmd_d.store = 32'(in_ch.address) < 32'(MAX_INPUTS);
        cmd_d.go    = in_ch.last;
      end
      // The unused opcode is taken and dropped.
      default: keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ch.ready) begin
      vld_q <= in_ch.valid && keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.ready && in_ch.valid) begin
      cmd_q <= cmd_d;
      val_q <= in_ch.value;
    end
  end

  assign push_valid_o = vld_q;
  assign push_cmd_o   = cmd_q;
  assign push_value_o = val_q;

endmodule

/* hdl/dlm_queue.sv */
// ----------------------------------------------------------------------------
// Dense layer command queue
// Small FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module dlm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = dlm_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign push_ready_o = cnt_q != CW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (32'(rd_q) == DEPTH - 1) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

/* hdl/dlm_back.sv */
// ----------------------------------------------------------------------------
// Dense layer back end
// Holds the weight, bias and input stores and runs the multiply-accumulate.
// ----------------------------------------------------------------------------
module dlm_back #(
  parameter int DATA_WIDTH  = dlm_pkg::DEF_DATA_WIDTH,
  parameter int MAX_INPUTS  = dlm_pkg::DEF_MAX_INPUTS,
  parameter int MAX_NEURONS = dlm_pkg::DEF_MAX_NEURONS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [dlm_pkg::IC_W-1:0]  input_count_i,
  input  logic [dlm_pkg::NC_W-1:0]  neuron_count_i,
  input  logic                      pop_valid_i,
  output logic                      pop_ready_o,
  input  dlm_pkg::cmd_t             pop_cmd_i,
  input  logic [DATA_WIDTH-1:0]     pop_value_i,
  dlm_out_if.source                 out_ch
);

  localparam int WDEPTH = MAX_INPUTS * MAX_NEURONS;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int IW     = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int NW     = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
  localparam int CW_I   = $clog2(MAX_INPUTS + 1);
  localparam int CW_N   = $clog2(MAX_NEURONS + 1);
  localparam int PW     = 2 * DATA_WIDTH;
  localparam int ACC_RAW = PW + $clog2(MAX_INPUTS + 1) + 2;
  localparam int ACC_W  = (ACC_RAW > dlm_pkg::SUM_W + 1) ? ACC_RAW : dlm_pkg::SUM_W + 1;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sh8000_0000);

  logic [DATA_WIDTH-1:0] wmem [WDEPTH];
  logic [DATA_WIDTH-1:0] bmem [MAX_NEURONS];
  logic [DATA_WIDTH-1:0] xmem [MAX_INPUTS];

  dlm_pkg::back_state_e state_q, state_d;
  logic [CW_I-1:0] c_q, c_d, ic;
  logic [CW_N-1:0] n_q, n_d, nc;
  logic [WAW-1:0]  wa_q, wa_d;
  logic            issue, first_issue, last_c, last_n, out_load;

  logic                         s1_vld_q, s1_first_q, s2_vld_q, s2_first_q;
  logic signed [DATA_WIDTH-1:0] x_q, w_q, b_q;
  logic signed [PW-1:0]         p_q;
  logic signed [ACC_W-1:0]      acc_q, acc_base;

  logic                             out_vld_q;
  logic [dlm_pkg::NIDX_W-1:0]       oidx_q;
  logic signed [dlm_pkg::SUM_W-1:0] osum_q, osum_d;
  logic                             osat_q, osat_d, olast_q;

  // Out-of-range counts are clamped to the supported range.
  always_comb begin
    if (input_count_i == '0) begin
      ic = CW_I'(1);
    end else if (32'(input_count_i) > 32'(MAX_INPUTS)) begin
      ic = CW_I'(MAX_INPUTS);
    end else begin
      ic = CW_I'(input_count_i);
    end
    if (neuron_count_i == '0) begin
      nc = CW_N'(1);
    end else if (32'(neuron_count_i) > 32'(MAX_NEURONS)) begin
      nc = CW_N'(MAX_NEURONS);
    end else begin
      nc = CW_N'(neuron_count_i);
    end
  end

  assign issue       = state_q == dlm_pkg::B_MAC;
  assign first_issue = issue && (c_q == '0);
  assign last_c      = CW_I'(c_q + 1'b1) == ic;
  assign last_n      = CW_N'(n_q + 1'b1) == nc;
  assign pop_ready_o = state_q == dlm_pkg::B_IDLE;
  assign out_load    = (state_q == dlm_pkg::B_DRAIN) && !s1_vld_q && !s2_vld_q &&
                       (!out_vld_q || out_ch.ready);

  always_comb begin
    state_d = state_q;
    c_d     = c_q;
    n_d     = n_q;
    wa_d    = wa_q;
    unique case (state_q)
      dlm_pkg::B_IDLE: begin
        if (pop_valid_i && pop_cmd_i.go) begin
          state_d = dlm_pkg::B_MAC;
          c_d     = '0;
          n_d     = '0;
          wa_d    = '0;
        end
      end
      dlm_pkg::B_MAC: begin
        c_d  = c_q + 1'b1;
        wa_d = wa_q + 1'b1;
        if (last_c) begin
          state_d = dlm_pkg::B_DRAIN;
        end
      end
      dlm_pkg::B_DRAIN: begin
        if (out_load) begin
          c_d     = '0;
          n_d     = n_q + 1'b1;
          state_d = last_n ? dlm_pkg::B_IDLE : dlm_pkg::B_MAC;
        end
      end
      default: state_d = dlm_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= dlm_pkg::B_IDLE;
      c_q        <= '0;
      n_q        <= '0;
      wa_q       <= '0;
      s1_vld_q   <= 1'b0;
      s1_first_q <= 1'b0;
      s2_vld_q   <= 1'b0;
      s2_first_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      c_q        <= c_d;
      n_q        <= n_d;
      wa_q       <= wa_d;
      s1_vld_q   <= issue;
      s1_first_q <= first_issue;
      s2_vld_q   <= s1_vld_q;
      s2_first_q <= s1_first_q;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Stores: written by popped commands, read with registered data.
  always_ff @(posedge clk_i) begin
    if (pop_ready_o && pop_valid_i && pop_cmd_i.store &&
        pop_cmd_i.kind == dlm_pkg::CMD_WEIGHT) begin
      wmem[WAW'(pop_cmd_i.addr)] <= pop_value_i;
    end
    if (issue) begin
      w_q <= wmem[wa_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_ready_o && pop_valid_i && pop_cmd_i.store &&
        pop_cmd_i.kind == dlm_pkg::CMD_BIAS) begin
      bmem[NW'(pop_cmd_i.addr)] <= pop_value_i;
    end
    if (first_issue) begin
      b_q <= bmem[n_q[NW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_ready_o && pop_valid_i && pop_cmd_i.store &&
        pop_cmd_i.kind == dlm_pkg::CMD_INPUT) begin
      xmem[IW'(pop_cmd_i.addr)] <= pop_value_i;
    end
    if (issue) begin
      x_q <= xmem[c_q[IW-1:0]];
    end
  end

  // The bias is aligned to the Q16.16 products before the first one is added.
  assign acc_base = s2_first_q ? (ACC_W'(b_q) <<< dlm_pkg::FRAC_BITS) : acc_q;

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      p_q <= x_q * w_q;
    end
    if (s2_vld_q) begin
      acc_q <= acc_base + ACC_W'(p_q);
    end
  end

  always_comb begin
    osat_d = 1'b1;
    if (acc_q > SAT_HI) begin
      osum_d = 32'sh7FFF_FFFF;
    end else if (acc_q < SAT_LO) begin
      osum_d = -32'sh8000_0000;
    end else begin
      osum_d = acc_q[dlm_pkg::SUM_W-1:0];
      osat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      oidx_q  <= dlm_pkg::NIDX_W'(n_q);
      osum_q  <= osum_d;
      osat_q  <= osat_d;
      olast_q <= last_n;
    end
  end

  assign out_ch.valid        = out_vld_q;
  assign out_ch.neuron_index = oidx_q;
  assign out_ch.sum          = osum_q;
  assign out_ch.saturated    = osat_q;
  assign out_ch.last_output  = olast_q;

endmodule

/* hdl/dense_layer_matvec.sv */
// ----------------------------------------------------------------------------
// Dense layer matrix-vector multiply
// Fully connected layer in Q8.8 fixed point with Q16.16 saturated outputs.
// ----------------------------------------------------------------------------
// Items arrive on in_ch: opcode 0 writes a weight (address neuron*count+column),
// opcode 1 a bias, opcode 2 one input element. An input element with last set
// starts the computation; one result per neuron then leaves on out_ch in neuron
// order, the final one with last_output set. Opcode 3 is taken and dropped.
// A computation feeds the input_count products of each neuron, one neuron after
// another, through the single multiply-accumulate unit and its two pipeline
// stages. A four-entry command queue lets new items be taken while the back
// end computes. When out_ch stalls the result is held and the next neuron
// waits. Reset clears control state and sets both counts to one; the stores
// are not cleared and must be written before use. The user must write
// input_count and neuron_count through cfg_* only while the block is idle;
// the block itself does not enforce this.
module dense_layer_matvec #(
  parameter int DATA_WIDTH  = dlm_pkg::DEF_DATA_WIDTH,
  parameter int MAX_INPUTS  = dlm_pkg::DEF_MAX_INPUTS,
  parameter int MAX_NEURONS = dlm_pkg::DEF_MAX_NEURONS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dlm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dlm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  dlm_in_if.sink                           in_ch,
  dlm_out_if.source                        out_ch
);

  localparam int QW = $bits(dlm_pkg::cmd_t) + DATA_WIDTH;

  logic [dlm_pkg::IC_W-1:0] input_count_q;
  logic [dlm_pkg::NC_W-1:0] neuron_count_q;

  logic                  push_valid, push_ready, pop_valid, pop_ready;
  dlm_pkg::cmd_t         push_cmd, pop_cmd;
  logic [DATA_WIDTH-1:0] push_value, pop_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      input_count_q  <= dlm_pkg::IC_W'(1);
      neuron_count_q <= dlm_pkg::NC_W'(1);
    end else if (cfg_we_i) begin
      unique case (dlm_pkg::cfg_index_e'(cfg_index_i))
        dlm_pkg::CFG_INPUT_COUNT:  input_count_q  <= cfg_data_i[dlm_pkg::IC_W-1:0];
        dlm_pkg::CFG_NEURON_COUNT: neuron_count_q <= cfg_data_i[dlm_pkg::NC_W-1:0];
        default: ;
      endcase
    end
  end

  dlm_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .MAX_INPUTS (MAX_INPUTS),
    .MAX_NEURONS(MAX_NEURONS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_cmd_o  (push_cmd),
    .push_value_o(push_value)
  );

  dlm_queue #(
    .WIDTH(QW),
    .DEPTH(dlm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i ({push_cmd, push_value}),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  ({pop_cmd, pop_value})
  );

  dlm_back #(
    .DATA_WIDTH (DATA_WIDTH),
    .MAX_INPUTS (MAX_INPUTS),
    .MAX_NEURONS(MAX_NEURONS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .input_count_i (input_count_q),
    .neuron_count_i(neuron_count_q),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_cmd_i     (pop_cmd),
    .pop_value_i   (pop_value),
    .out_ch        (out_ch)
  );

endmodule

/* hdl/dlm_checker.sv */
// ----------------------------------------------------------------------------
// Dense layer checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dlm_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [dlm_pkg::NIDX_W-1:0]       out_index_i,
  input logic signed [dlm_pkg::SUM_W-1:0] out_sum_i,
  input logic                             out_sat_i
);

  // A flagged result carries one of the two clipping values.
  `DLM_ASSERT(a_sat_value, clk_i, rst_ni, out_valid_i && out_sat_i |-> (out_sum_i == 32'sh7FFF_FFFF || out_sum_i == -32'sh8000_0000))
  // No result is offered while reset is held.
  `DLM_ASSERT_RST(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_i)
  `DLM_ASSERT(a_valid_holds, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)
  `DLM_ASSERT(a_result_holds, clk_i, rst_ni, out_valid_i && !out_ready_i |=> $stable(out_index_i) && $stable(out_sum_i))

endmodule

bind dense_layer_matvec dlm_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_ch.valid),
  .out_ready_i(out_ch.ready),
  .out_index_i(out_ch.neuron_index),
  .out_sum_i  (out_ch.sum),
  .out_sat_i  (out_ch.saturated)
);
